@@ rtl/core/imhc_pkg.sv @@
// ----------------------------------------------------------------------------
// imhc_pkg
// Shared types, constants and helper functions of the iterated MD5 hex chain.
// ----------------------------------------------------------------------------
package imhc_pkg;

   // message length field, wide enough for the largest buffer
   localparam int LEN_W = 7;
   localparam logic [LEN_W-1:0] MAX_OUT = LEN_W'(64);
   localparam logic [LEN_W-1:0] TWO_BLOCK_LEN = LEN_W'(56);

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [31:0] MD5_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   localparam logic [4:0] MD5_S [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // job handed from the intake side to the hash engine
   typedef struct packed {
      logic [LEN_W-1:0] len;
      logic             too_long;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_STEP,
      ST_ADD,
      ST_HEXLOAD,
      ST_EMIT,
      ST_ECHO
   } state_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
      logic [63:0] t;
      t = {x, x} << s;
      return t[63:32];
   endfunction

   // lowercase ascii hex digit of one nibble
   function automatic logic [7:0] hex_ascii(input logic [3:0] n);
      logic [7:0] r;
      if (n < 4'd10) begin
         r = 8'h30 + {4'h0, n};
      end else begin
         r = 8'h57 + {4'h0, n};
      end
      return r;
   endfunction

   // character t of the hex text of a digest, high nibble of byte 0 first
   function automatic logic [7:0] digest_char(input logic [127:0] dig, input logic [4:0] t);
      logic [6:0] idx;
      idx = {t[4:1], ~t[0], 2'b00};
      return hex_ascii(dig[idx +: 4]);
   endfunction

endpackage

@@ rtl/core/imhc_front.sv @@
// ----------------------------------------------------------------------------
// imhc_front
// Byte intake: stores message bytes, tracks length and overflow, and queues
// one finished message as a job for the hash engine.
// ----------------------------------------------------------------------------
module imhc_front #(
   parameter int MAX_MSG_BYTES = 64,
   parameter int ROUND_BITS    = 16,
   parameter int AW            = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [7:0]             req_msg_byte,
   input  logic                   req_msg_last,
   input  logic [ROUND_BITS-1:0]  req_round_count,
   input  logic                   back_busy,
   input  logic                   job_pop,
   output logic                   busy,
   output logic                   job_valid,
   output imhc_pkg::job_type      job,
   output logic [ROUND_BITS-1:0]  job_rounds,
   input  logic [AW-1:0]          rd_addr,
   output logic [7:0]             rd_data
);
   import imhc_pkg::*;

   logic [7:0]            mem [MAX_MSG_BYTES];
   logic [LEN_W-1:0]      len_ff, len_in;
   logic                  ovf_ff, ovf_in;
   logic                  jv_ff, jv_in;
   job_type               job_ff, job_in;
   logic [ROUND_BITS-1:0] rounds_ff, rounds_in;
   logic [7:0]            rd_ff;
   logic                  accept;
   logic                  has_room;

   assign busy     = jv_ff | back_busy;
   assign accept   = start & ~busy;
   assign has_room = len_ff < LEN_W'(MAX_MSG_BYTES);

   // message store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (accept && has_room) begin
         mem[len_ff[AW-1:0]] <= req_msg_byte;
      end
      rd_ff <= mem[rd_addr];
   end

   // length, overflow and job queue
   always_comb begin
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      jv_in     = jv_ff & ~job_pop;
      job_in    = job_ff;
      rounds_in = rounds_ff;
      if (accept) begin
         if (has_room) begin
            len_in = len_ff + LEN_W'(1);
         end else begin
            ovf_in = 1'b1;
         end
         if (req_msg_last) begin
            jv_in           = 1'b1;
            job_in.len      = len_in;
            job_in.too_long = ovf_in;
            rounds_in       = req_round_count;
            len_in          = '0;
            ovf_in          = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         ovf_ff <= 1'b0;
         jv_ff  <= 1'b0;
      end else begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         jv_ff  <= jv_in;
      end
      job_ff    <= job_in;
      rounds_ff <= rounds_in;
   end

   assign job_valid  = jv_ff;
   assign job        = job_ff;
   assign job_rounds = rounds_ff;
   assign rd_data    = rd_ff;

endmodule

@@ rtl/core/imhc_back.sv @@
// ----------------------------------------------------------------------------
// imhc_back
// Hash engine: pads and loads blocks, runs MD5 one step per cycle, chains
// rounds over the hex text, and drives the result words.
// ----------------------------------------------------------------------------
module imhc_back #(
   parameter int ROUND_BITS = 16,
   parameter int AW         = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   input  imhc_pkg::job_type      job,
   input  logic [ROUND_BITS-1:0]  job_rounds,
   output logic                   job_pop,
   output logic                   back_busy,
   output logic [AW-1:0]          rd_addr,
   input  logic [7:0]             rd_data,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_char,
   output logic                   rsp_out_last,
   output logic                   rsp_too_long
);
   import imhc_pkg::*;

   state_type             st_ff, st_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [31:0]           h_ff [4];
   logic [31:0]           h_in [4];
   logic [31:0]           w_ff [16];
   logic                  blk_ff, blk_in, two_ff, two_in, hex_ff, hex_in, tl_ff, tl_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ROUND_BITS-1:0] rem_ff, rem_in;
   logic                  fill_v_ff, fill_v_in;
   logic [6:0]            fill_p_ff, fill_p_in;
   logic                  echo_v_ff, echo_v_in, echo_last_ff, echo_last_in;
   logic                  hex_load;
   logic                  rv_ff, rv_in, rl_ff, rl_in;
   logic [7:0]            rc_ff, rc_in;
   logic [127:0]          dig;
   logic [7:0]            fill_byte;
   logic [6:0]            fill_pos;
   // step datapath
   logic [3:0]            g;
   logic [31:0]           f, sum;
   logic [5:0]            si;

   assign dig = {h_ff[3], h_ff[2], h_ff[1], h_ff[0]};
   assign si  = cnt_ff[5:0];
   assign fill_pos = {blk_ff, cnt_ff[5:0]};

   // round function and word index of the current step
   always_comb begin
      unique case (si[5:4])
         2'd0: begin
            f = (b_ff & c_ff) | (~b_ff & d_ff);
            g = si[3:0];
         end
         2'd1: begin
            f = (d_ff & b_ff) | (~d_ff & c_ff);
            g = 4'(5 * si[3:0] + 1);
         end
         2'd2: begin
            f = b_ff ^ c_ff ^ d_ff;
            g = 4'(3 * si[3:0] + 5);
         end
         default: begin
            f = c_ff ^ (b_ff | ~d_ff);
            g = 4'(7 * si[3:0]);
         end
      endcase
      sum = f + a_ff + MD5_K[si] + w_ff[g];
   end

   // padded block byte for the fill stage
   always_comb begin
      priority if (fill_p_ff < len_ff) begin
         fill_byte = rd_data;
      end else if (fill_p_ff == len_ff) begin
         fill_byte = 8'h80;
      end else if (fill_p_ff[6] == two_ff && fill_p_ff[5:3] == 3'd7
                   && fill_p_ff[2:0] == 3'd0) begin
         fill_byte = {len_ff[4:0], 3'b000};
      end else if (fill_p_ff[6] == two_ff && fill_p_ff[5:3] == 3'd7
                   && fill_p_ff[2:0] == 3'd1) begin
         fill_byte = {6'd0, len_ff[6:5]};
      end else begin
         fill_byte = 8'h00;
      end
   end

   // sequencer and datapath next values
   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      h_in         = h_ff;
      blk_in       = blk_ff;
      two_in       = two_ff;
      hex_in       = hex_ff;
      tl_in        = tl_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      fill_v_in    = 1'b0;
      fill_p_in    = fill_p_ff;
      echo_v_in    = 1'b0;
      echo_last_in = 1'b0;
      hex_load     = 1'b0;
      job_pop      = 1'b0;
      rd_addr      = '0;
      rv_in        = 1'b0;
      rl_in        = 1'b0;
      rc_in        = rc_ff;

      // echoed byte goes out from the registered store read data
      if (echo_v_ff) begin
         rv_in = 1'b1;
         rc_in = rd_data;
         rl_in = echo_last_ff;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               tl_in   = job.too_long;
               cnt_in  = '0;
               hex_in  = 1'b0;
               if (job_rounds == '0) begin
                  len_in = (job.len > MAX_OUT) ? MAX_OUT : job.len;
                  st_in  = ST_ECHO;
               end else begin
                  len_in = job.len;
                  h_in   = '{IV_A, IV_B, IV_C, IV_D};
                  blk_in = 1'b0;
                  two_in = job.len >= TWO_BLOCK_LEN;
                  rem_in = job_rounds - ROUND_BITS'(1);
                  st_in  = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            if (!cnt_ff[6]) begin
               rd_addr   = fill_pos[AW-1:0];
               fill_v_in = 1'b1;
               fill_p_in = fill_pos;
               cnt_in    = cnt_ff + 7'd1;
            end else begin
               cnt_in = '0;
               a_in   = h_ff[0];
               b_in   = h_ff[1];
               c_in   = h_ff[2];
               d_in   = h_ff[3];
               st_in  = ST_STEP;
            end
         end
         ST_STEP: begin
            a_in   = d_ff;
            d_in   = c_ff;
            c_in   = b_ff;
            b_in   = b_ff + rotl32(sum, MD5_S[{si[5:4], si[1:0]}]);
            cnt_in = cnt_ff + 7'd1;
            if (si == 6'd63) begin
               st_in = ST_ADD;
            end
         end
         ST_ADD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            cnt_in  = '0;
            priority if (!hex_ff && !blk_ff && two_ff) begin
               blk_in = 1'b1;
               st_in  = ST_FILL;
            end else if (rem_ff != '0) begin
               st_in = ST_HEXLOAD;
            end else begin
               st_in = ST_EMIT;
            end
         end
         ST_HEXLOAD: begin
            hex_load = 1'b1;
            h_in     = '{IV_A, IV_B, IV_C, IV_D};
            a_in     = IV_A;
            b_in     = IV_B;
            c_in     = IV_C;
            d_in     = IV_D;
            rem_in   = rem_ff - ROUND_BITS'(1);
            hex_in   = 1'b1;
            cnt_in   = '0;
            st_in    = ST_STEP;
         end
         ST_EMIT: begin
            rv_in  = 1'b1;
            rc_in  = digest_char(dig, cnt_ff[4:0]);
            rl_in  = cnt_ff[4:0] == 5'd31;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[4:0] == 5'd31) begin
               st_in = ST_IDLE;
            end
         end
         ST_ECHO: begin
            if (cnt_ff < len_ff) begin
               rd_addr      = cnt_ff[AW-1:0];
               echo_v_in    = 1'b1;
               echo_last_in = (cnt_ff + 7'd1) == len_ff;
               cnt_in       = cnt_ff + 7'd1;
            end else begin
               st_in = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= ST_IDLE;
         fill_v_ff <= 1'b0;
         echo_v_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         fill_v_ff <= fill_v_in;
         echo_v_ff <= echo_v_in;
         rv_ff     <= rv_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff       <= cnt_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      h_ff         <= h_in;
      blk_ff       <= blk_in;
      two_ff       <= two_in;
      hex_ff       <= hex_in;
      tl_ff        <= tl_in;
      len_ff       <= len_in;
      rem_ff       <= rem_in;
      fill_p_ff    <= fill_p_in;
      echo_last_ff <= echo_last_in;
      rc_ff        <= rc_in;
      rl_ff        <= rl_in;
   end

   // block buffer: byte fill from the store or whole hex text at once
   always_ff @(posedge clock) begin
      if (hex_load) begin
         for (int k = 0; k < 16; k++) begin
            if (k < 8) begin
               w_ff[k] <= {digest_char(dig, 5'(4 * k + 3)), digest_char(dig, 5'(4 * k + 2)),
                           digest_char(dig, 5'(4 * k + 1)), digest_char(dig, 5'(4 * k))};
            end else if (k == 8) begin
               w_ff[k] <= 32'h0000_0080;
            end else if (k == 14) begin
               w_ff[k] <= 32'h0000_0100;
            end else begin
               w_ff[k] <= 32'h0;
            end
         end
      end else if (fill_v_ff) begin
         w_ff[fill_p_ff[5:2]][{fill_p_ff[1:0], 3'b000} +: 8] <= fill_byte;
      end
   end

   assign back_busy    = st_ff != ST_IDLE;
   assign rsp_valid    = rv_ff;
   assign rsp_out_char = rc_ff;
   assign rsp_out_last = rl_ff;
   assign rsp_too_long = tl_ff;

endmodule

@@ rtl/core/iterated_md5_hex_chain.sv @@
// ----------------------------------------------------------------------------
// iterated_md5_hex_chain
// Chained MD5 over a password and salt, emitting the final digest as hex.
//
// Input words come in on req_* and are taken when start is high and busy
// is low, one message byte per word. The word with req_msg_last set closes
// the message and carries the round count. Bytes past the buffer are dropped
// and rsp_too_long is then set on every result word of that message.
// Results leave on rsp_* with rsp_valid high for one cycle each and cannot
// be held off; the receiver must take every word.
// One byte is taken per cycle while busy is low. After the last byte a round
// count of zero echoes up to 64 stored bytes, one per cycle. Otherwise each
// MD5 block is loaded a byte at a time from the store, run through 64 steps
// and added in (two blocks for messages of 56 bytes or more), each further
// round loads the hex text at once and runs the steps again, and then 32 hex
// characters follow, one per cycle. The hash engine has a single shared step
// unit. busy stays high from the last byte until the last result word is sent.
// Reset clears the control state; the message store needs no clearing.
// ----------------------------------------------------------------------------
module iterated_md5_hex_chain #(
   parameter int MAX_MSG_BYTES = 64,
   parameter int ROUND_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [7:0]            req_msg_byte,
   input  logic                  req_msg_last,
   input  logic [ROUND_BITS-1:0] req_round_count,
   output logic                  rsp_valid,
   output logic [7:0]            rsp_out_char,
   output logic                  rsp_out_last,
   output logic                  rsp_too_long
);
   import imhc_pkg::*;

   localparam int AW = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;

   logic                  back_busy;
   logic                  job_pop;
   logic                  job_valid;
   job_type               job;
   logic [ROUND_BITS-1:0] job_rounds;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;

   // intake side
   imhc_front #(
      .MAX_MSG_BYTES (MAX_MSG_BYTES),
      .ROUND_BITS    (ROUND_BITS),
      .AW            (AW)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .req_msg_byte    (req_msg_byte),
      .req_msg_last    (req_msg_last),
      .req_round_count (req_round_count),
      .back_busy       (back_busy),
      .job_pop         (job_pop),
      .busy            (busy),
      .job_valid       (job_valid),
      .job             (job),
      .job_rounds      (job_rounds),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

   // hash engine
   imhc_back #(
      .ROUND_BITS (ROUND_BITS),
      .AW         (AW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job          (job),
      .job_rounds   (job_rounds),
      .job_pop      (job_pop),
      .back_busy    (back_busy),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last),
      .rsp_too_long (rsp_too_long)
   );

endmodule

@@ sim/iterated_md5_hex_chain_tb.sv @@
// ----------------------------------------------------------------------------
// iterated_md5_hex_chain_tb
// Self-checking bench for the chained MD5 hex block.
//
// Messages are sent one byte per word. A scoreboard keeps its own copy of
// the message store and computes the expected hex text or echo on the
// closing byte. Every result word is checked against the oldest expected
// character. Sender gaps vary by phase; a watchdog guards against hangs.
// ----------------------------------------------------------------------------
module iterated_md5_hex_chain_tb;

   import imhc_pkg::*;

   localparam int STORE_DEPTH = 64;
   localparam int ECHO_MAX    = 64;
   localparam int STALL_LIMIT = 20000000;

   typedef struct {
      logic [7:0] ch;
      logic       last;
      logic       too_long;
   } char_word_type;

   // ------------------------------------------------------------------------
   // scoreboard: message store copy, md5 chain and expected character queue
   // ------------------------------------------------------------------------
   class md5_board_type;
      logic [7:0]    msg_store [STORE_DEPTH];
      int            msg_len;
      bit            overflow;
      logic [31:0]   sine_k [64];
      int            shift_amt [16];
      char_word_type expected_chars [$];
      int            errors;

      function new();
         int i;
         shift_amt = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
         for (i = 0; i < 64; i++)
            sine_k[i] = 32'(longint'($floor($sqrt($sin(i + 1.0) * $sin(i + 1.0))
                                              * 4294967296.0)));
         msg_len = 0;
         overflow = 0;
         errors = 0;
      endfunction

      function logic [31:0] rot_left(logic [31:0] x, int s);
         return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
      endfunction

      function logic [7:0] nibble_char(logic [3:0] n);
         return (n < 10) ? 8'h30 + n : 8'h57 + n;
      endfunction

      // digest byte i sits at bits [8*i +: 8]
      function logic [127:0] md5_digest(logic [7:0] m [128], int len);
         logic [7:0]  pad [128];
         logic [31:0] st [4];
         logic [31:0] w [16];
         logic [31:0] a, b, c, d, f;
         logic [63:0] nbits;
         logic [127:0] dig;
         int nblk, blk, i, g;
         for (i = 0; i < 128; i++) pad[i] = (i < len) ? m[i] : 8'h00;
         pad[len] = 8'h80;
         nblk = (len + 8) / 64 + 1;
         nbits = 64'(len) * 8;
         for (i = 0; i < 8; i++) pad[nblk * 64 - 8 + i] = nbits[8*i +: 8];
         st = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
         for (blk = 0; blk < nblk; blk++) begin
            for (i = 0; i < 16; i++)
               w[i] = {pad[blk*64 + 4*i + 3], pad[blk*64 + 4*i + 2],
                       pad[blk*64 + 4*i + 1], pad[blk*64 + 4*i]};
            a = st[0]; b = st[1]; c = st[2]; d = st[3];
            for (i = 0; i < 64; i++) begin
               if (i < 16) begin
                  f = (b & c) | (~b & d); g = i;
               end else if (i < 32) begin
                  f = (d & b) | (~d & c); g = (5*i + 1) % 16;
               end else if (i < 48) begin
                  f = b ^ c ^ d; g = (3*i + 5) % 16;
               end else begin
                  f = c ^ (b | ~d); g = (7*i) % 16;
               end
               f = f + a + sine_k[i] + w[g];
               a = d; d = c; c = b;
               b = b + rot_left(f, shift_amt[(i / 16) * 4 + i % 4]);
            end
            st[0] += a; st[1] += b; st[2] += c; st[3] += d;
         end
         dig = {st[3], st[2], st[1], st[0]};
         return dig;
      endfunction

      function void hex_text(logic [127:0] dig, ref logic [7:0] txt [128]);
         int i;
         for (i = 0; i < 16; i++) begin
            txt[2*i]     = nibble_char(dig[8*i + 4 +: 4]);
            txt[2*i + 1] = nibble_char(dig[8*i +: 4]);
         end
      endfunction

      // note one accepted input word
      function void note_word(logic [7:0] b, logic last, logic [15:0] rounds);
         logic [7:0]    buf_m [128];
         logic [127:0]  dig;
         char_word_type cw;
         int i, cnt;
         if (msg_len < STORE_DEPTH) begin
            msg_store[msg_len] = b;
            msg_len++;
         end else begin
            overflow = 1;
         end
         if (!last) return;
         if (rounds == 0) begin
            cnt = (msg_len > ECHO_MAX) ? ECHO_MAX : msg_len;
            for (i = 0; i < cnt; i++) begin
               cw.ch = msg_store[i]; cw.last = (i == cnt - 1); cw.too_long = overflow;
               expected_chars.push_back(cw);
            end
         end else begin
            for (i = 0; i < 128; i++) buf_m[i] = (i < msg_len) ? msg_store[i] : 8'h00;
            dig = md5_digest(buf_m, msg_len);
            for (i = 1; i < rounds; i++) begin
               hex_text(dig, buf_m);
               dig = md5_digest(buf_m, 32);
            end
            hex_text(dig, buf_m);
            for (i = 0; i < 32; i++) begin
               cw.ch = buf_m[i]; cw.last = (i == 31); cw.too_long = overflow;
               expected_chars.push_back(cw);
            end
         end
         msg_len = 0;
         overflow = 0;
      endfunction

      // compare one result word with the oldest expected character
      function void check_char(logic [7:0] ch, logic last, logic too_long);
         char_word_type cw;
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected word ch=%h last=%b too_long=%b",
                     $time, ch, last, too_long);
            errors++;
            return;
         end
         cw = expected_chars.pop_front();
         if (ch !== cw.ch) begin
            $display("%0t: out_char expected %h actual %h", $time, cw.ch, ch);
            errors++;
         end
         if (last !== cw.last) begin
            $display("%0t: out_last expected %b actual %b", $time, cw.last, last);
            errors++;
         end
         if (too_long !== cw.too_long) begin
            $display("%0t: too_long expected %b actual %b", $time, cw.too_long, too_long);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [7:0]  req_msg_byte = '0;
   logic        req_msg_last = 0;
   logic [15:0] req_round_count = '0;
   logic        rsp_valid;
   logic [7:0]  rsp_out_char;
   logic        rsp_out_last;
   logic        rsp_too_long;

   md5_board_type board = new();
   int  gap_pct = 13;
   int  words_sent = 0;
   int  stall_count = 0;

   iterated_md5_hex_chain dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_msg_byte(req_msg_byte), .req_msg_last(req_msg_last),
      .req_round_count(req_round_count), .rsp_valid(rsp_valid),
      .rsp_out_char(rsp_out_char), .rsp_out_last(rsp_out_last),
      .rsp_too_long(rsp_too_long)
   );

   // clock
   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_char(rsp_out_char, rsp_out_last, rsp_too_long);
   end

   // watchdog on cycles with no word moving
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count >= STALL_LIMIT) begin
            $display("iterated_md5_hex_chain: mismatch");
            $finish;
         end
      end
   end

   // send one word, with a random gap in front
   task automatic send_word(logic [7:0] b, logic last, logic [15:0] rounds);
      if ($urandom_range(99) < gap_pct) begin
         start <= 0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      start <= 1;
      req_msg_byte <= b;
      req_msg_last <= last;
      req_round_count <= rounds;
      do @(posedge clock); while (busy);
      board.note_word(b, last, rounds);
      words_sent++;
   endtask

   // whole message; round count on earlier bytes is noise
   task automatic send_message(int len, logic [15:0] rounds);
      int i;
      for (i = 0; i < len; i++)
         send_word(8'($urandom), i == len - 1,
                   (i == len - 1) ? rounds : 16'($urandom));
   endtask

   initial begin
      int len, rounds;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: extremes, echo, two-block padding, overflow
      send_word(8'h00, 1, 16'd1);
      send_word(8'hff, 1, 16'd0);
      send_word(8'h61, 1, 16'hffff);
      send_message(3, 16'd2);
      send_message(55, 16'd1);
      send_message(56, 16'd1);
      send_message(64, 16'd0);
      send_message(64, 16'd2);
      send_message(70, 16'd0);
      send_message(67, 16'd3);

      // random messages, heavy sender idling first and then none
      while (words_sent < 450) begin
         gap_pct = (words_sent < 416) ? 65 : 0;
         case ($urandom_range(9))
            0: len = $urandom_range(50, 63);
            1: len = $urandom_range(64, 75);
            default: len = $urandom_range(1, 16);
         endcase
         case ($urandom_range(9))
            0, 1: rounds = 0;
            2: rounds = $urandom_range(5, 40);
            default: rounds = $urandom_range(1, 4);
         endcase
         send_message(len, 16'(rounds));
      end
      start <= 0;

      while (board.expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (board.errors == 0 && board.expected_chars.size() == 0) begin
         $display("iterated_md5_hex_chain: match");
      end else begin
         $display("iterated_md5_hex_chain: mismatch");
      end
      $finish;
   end

endmodule
